@@ src/hbr_pkg.sv @@
// Package for the heartbeat registry: table depth, message codes, status codes,
// cell command and entry types. No dependencies.
package hbr_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int COUNT_W     = 5;

   localparam logic [15:0] TIMEOUT_RESET = 16'd450;
   localparam logic [31:0] LOOPBACK_IP   = 32'h7F00_0001;

   localparam logic [7:0] MSG_KEEPALIVE = 8'h6B;
   localparam logic [7:0] MSG_ADD       = 8'h61;
   localparam logic [7:0] MSG_CLOSE     = 8'h43;
   localparam logic [7:0] MSG_LIST      = 8'h63;
   localparam logic [7:0] MSG_QUERY     = 8'h79;

   localparam logic REG_TIMEOUT  = 1'b0;
   localparam logic REG_LOCAL_IP = 1'b1;

   typedef enum logic [3:0] {
      ST_REFRESHED = 4'd0,
      ST_ADDED     = 4'd1,
      ST_FULL      = 4'd2,
      ST_REMOVED   = 4'd3,
      ST_NOT_FOUND = 4'd4,
      ST_HEADER    = 4'd5,
      ST_ENTRY     = 4'd6,
      ST_UNKNOWN   = 4'd7,
      ST_TICK_DONE = 4'd8
   } status_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_MARK_MATCH,
      CELL_MARK_AGE,
      CELL_TOUCH,
      CELL_PUSH,
      CELL_PULL
   } cell_op_type;

   typedef struct packed {
      logic [31:0] ip;
      logic [15:0] port;
      logic [31:0] seen;
   } entry_type;

   typedef struct packed {
      cell_op_type op;
      logic [31:0] key_ip;
      logic [15:0] key_port;
      logic [31:0] now;
      logic [15:0] timeout;
   } cell_cmd_type;

endpackage

@@ src/hbr_cell.sv @@
// One registry cell: holds one entry and its mark flag, shifts with its neighbors.
// Depends on hbr_pkg.
module hbr_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  hbr_pkg::cell_cmd_type cmd_in,
   input  logic                  valid_in,
   input  hbr_pkg::entry_type    left_entry_in,
   input  hbr_pkg::entry_type    right_entry_in,
   input  logic                  right_kill_in,
   input  logic                  shift_in,
   output hbr_pkg::entry_type    entry_out,
   output logic                  kill_out,
   output logic                  shift_out
);

   hbr_pkg::entry_type entry_ff, entry_in;
   logic               kill_ff, kill_in;
   logic [32:0]        limit;

   assign shift_out = shift_in | kill_ff;
   assign entry_out = entry_ff;
   assign kill_out  = kill_ff;

   always_comb begin
      entry_in = entry_ff;
      kill_in  = kill_ff;
      limit    = {1'b0, entry_ff.seen} + {17'b0, cmd_in.timeout};
      unique case (cmd_in.op)
         hbr_pkg::CELL_HOLD: begin
         end
         hbr_pkg::CELL_MARK_MATCH: begin
            kill_in = valid_in && (entry_ff.ip == cmd_in.key_ip)
                      && (entry_ff.port == cmd_in.key_port);
         end
         hbr_pkg::CELL_MARK_AGE: begin
            kill_in = valid_in && (limit < {1'b0, cmd_in.now});
         end
         hbr_pkg::CELL_TOUCH: begin
            if (kill_ff) begin
               entry_in.seen = cmd_in.now;
            end
         end
         hbr_pkg::CELL_PUSH: begin
            entry_in = left_entry_in;
         end
         hbr_pkg::CELL_PULL: begin
            if (shift_out) begin
               entry_in = right_entry_in;
               kill_in  = right_kill_in;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kill_ff <= 1'b0;
      end else begin
         kill_ff <= kill_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

@@ src/heartbeat_registry_with_aging.sv @@
// Heartbeat registry top level: request decode, sequencer and a row of hbr_cell.
// Depends on hbr_pkg and hbr_cell.
//
//   channel  ports                         handshake
//   request  req_* fields                  start high while busy low
//   result   rsp_* fields                  rsp_valid, one cycle, no back-pressure
//   config   csr_index, csr_wdata          csr_wr_en, taken at once
//
// Keepalive, add, close and unknown requests give one result. A list gives a
// header and then one result per entry read from the row. An aging tick takes
// one row compaction step per expired entry, then gives one result.
// Reset empties the table at once; no clearing pass.
// The receiver cannot stall; each result shows for one cycle after its edge.
module heartbeat_registry_with_aging (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_mode,
   input  logic [7:0]  req_first_byte,
   input  logic [7:0]  req_second_byte,
   input  logic [31:0] req_src_ip,
   input  logic [15:0] req_src_port,
   input  logic [31:0] req_now_seconds,
   output logic        rsp_valid,
   output logic [3:0]  rsp_status,
   output logic [31:0] rsp_entry_ip,
   output logic [15:0] rsp_entry_port,
   output logic [4:0]  rsp_entry_count,
   output logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int DEPTH = hbr_pkg::TABLE_DEPTH;
   localparam int IDX_W = hbr_pkg::IDX_W;
   localparam int CNT_W = hbr_pkg::CNT_W;
   localparam int COUNT_W = hbr_pkg::COUNT_W;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EXEC = 4'b0010,
      S_LIST = 4'b0100,
      S_AGE  = 4'b1000
   } state_type;

   typedef enum logic [1:0] {
      CLS_KEEP,
      CLS_REMOVE,
      CLS_LIST,
      CLS_UNKNOWN
   } class_type;

   state_type            state_ff, state_in;
   class_type            class_ff, class_in, req_class;
   logic [15:0]          timeout_ff;
   logic [31:0]          local_ip_ff;
   logic [CNT_W-1:0]     occ_ff, occ_in;
   logic [CNT_W-1:0]     removed_ff, removed_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [31:0]          key_ip_ff, key_ip_in, key_sel;
   logic [15:0]          port_ff, port_in;
   logic [31:0]          now_ff, now_in;

   logic                 out_valid_ff, out_valid_in;
   hbr_pkg::status_type  out_status_ff, out_status_in;
   logic [31:0]          out_ip_ff, out_ip_in;
   logic [15:0]          out_port_ff, out_port_in;
   logic [COUNT_W-1:0]   out_count_ff, out_count_in;
   logic                 out_last_ff, out_last_in;

   hbr_pkg::cell_cmd_type cmd;
   hbr_pkg::entry_type    new_entry;
   hbr_pkg::entry_type    entry_w [DEPTH];
   logic [DEPTH-1:0]      kill_vec;
   logic [DEPTH:0]        shift_w;
   logic                  any_kill;
   logic                  accept;
   logic                  list_last;

   assign accept    = start && (state_ff == S_IDLE);
   assign busy      = (state_ff != S_IDLE);
   assign any_kill  = |kill_vec;
   assign shift_w[0] = 1'b0;
   assign list_last = ((CNT_W'(idx_ff) + CNT_W'(1)) == occ_ff);

   assign new_entry.ip   = key_ip_ff;
   assign new_entry.port = port_ff;
   assign new_entry.seen = now_ff;

   // cell row
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      hbr_pkg::entry_type left_entry, right_entry;
      logic               right_kill;
      if (i == 0) begin : g_head
         assign left_entry = new_entry;
      end else begin : g_body
         assign left_entry = entry_w[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign right_entry = entry_w[i];
         assign right_kill  = 1'b0;
      end else begin : g_inner
         assign right_entry = entry_w[i+1];
         assign right_kill  = kill_vec[i+1];
      end
      hbr_cell u_cell (
         .clock          (clock),
         .reset          (reset),
         .cmd_in         (cmd),
         .valid_in       (CNT_W'(i) < occ_ff),
         .left_entry_in  (left_entry),
         .right_entry_in (right_entry),
         .right_kill_in  (right_kill),
         .shift_in       (shift_w[i]),
         .entry_out      (entry_w[i]),
         .kill_out       (kill_vec[i]),
         .shift_out      (shift_w[i+1])
      );
   end

   always_comb begin
      unique case (req_second_byte) inside
         hbr_pkg::MSG_KEEPALIVE, hbr_pkg::MSG_ADD: req_class = CLS_KEEP;
         hbr_pkg::MSG_CLOSE:                      req_class = CLS_REMOVE;
         hbr_pkg::MSG_LIST:                       req_class = CLS_LIST;
         hbr_pkg::MSG_QUERY: begin
            req_class = (req_first_byte == 8'd0) ? CLS_LIST : CLS_UNKNOWN;
         end
         default:                                 req_class = CLS_UNKNOWN;
      endcase
      key_sel = req_src_ip;
      if ((req_class == CLS_KEEP || req_class == CLS_REMOVE)
          && req_src_ip == hbr_pkg::LOOPBACK_IP && local_ip_ff != 32'd0) begin
         key_sel = local_ip_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      class_in      = class_ff;
      occ_in        = occ_ff;
      removed_in    = removed_ff;
      idx_in        = idx_ff;
      key_ip_in     = key_ip_ff;
      port_in       = port_ff;
      now_in        = now_ff;
      out_valid_in  = 1'b0;
      out_status_in = out_status_ff;
      out_ip_in     = out_ip_ff;
      out_port_in   = out_port_ff;
      out_count_in  = out_count_ff;
      out_last_in   = out_last_ff;

      cmd.op       = hbr_pkg::CELL_HOLD;
      cmd.key_ip   = key_ip_ff;
      cmd.key_port = port_ff;
      cmd.now      = now_ff;
      cmd.timeout  = timeout_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               class_in     = req_class;
               key_ip_in    = key_sel;
               port_in      = req_src_port;
               now_in       = req_now_seconds;
               removed_in   = '0;
               idx_in       = '0;
               cmd.key_ip   = key_sel;
               cmd.key_port = req_src_port;
               cmd.now      = req_now_seconds;
               if (req_mode) begin
                  cmd.op   = hbr_pkg::CELL_MARK_AGE;
                  state_in = S_AGE;
               end else begin
                  if (req_class == CLS_KEEP || req_class == CLS_REMOVE) begin
                     cmd.op = hbr_pkg::CELL_MARK_MATCH;
                  end
                  state_in = S_EXEC;
               end
            end
         end
         S_EXEC: begin
            out_valid_in = 1'b1;
            out_ip_in    = key_ip_ff;
            out_port_in  = port_ff;
            out_count_in = '0;
            out_last_in  = 1'b1;
            state_in     = S_IDLE;
            unique case (class_ff)
               CLS_KEEP: begin
                  if (any_kill) begin
                     cmd.op        = hbr_pkg::CELL_TOUCH;
                     out_status_in = hbr_pkg::ST_REFRESHED;
                  end else if (occ_ff != CNT_W'(DEPTH)) begin
                     cmd.op        = hbr_pkg::CELL_PUSH;
                     occ_in        = occ_ff + CNT_W'(1);
                     out_status_in = hbr_pkg::ST_ADDED;
                  end else begin
                     out_status_in = hbr_pkg::ST_FULL;
                  end
               end
               CLS_REMOVE: begin
                  if (any_kill) begin
                     cmd.op        = hbr_pkg::CELL_PULL;
                     occ_in        = occ_ff - CNT_W'(1);
                     out_status_in = hbr_pkg::ST_REMOVED;
                  end else begin
                     out_status_in = hbr_pkg::ST_NOT_FOUND;
                  end
               end
               CLS_LIST: begin
                  out_status_in = hbr_pkg::ST_HEADER;
                  out_ip_in     = '0;
                  out_port_in   = '0;
                  out_count_in  = COUNT_W'(occ_ff);
                  out_last_in   = (occ_ff == '0);
                  if (occ_ff != '0) begin
                     state_in = S_LIST;
                  end
               end
               CLS_UNKNOWN: begin
                  out_status_in = hbr_pkg::ST_UNKNOWN;
               end
               default: begin
                  out_status_in = hbr_pkg::ST_UNKNOWN;
               end
            endcase
         end
         S_LIST: begin
            out_valid_in  = 1'b1;
            out_status_in = hbr_pkg::ST_ENTRY;
            out_ip_in     = entry_w[idx_ff].ip;
            out_port_in   = entry_w[idx_ff].port;
            out_count_in  = '0;
            out_last_in   = list_last;
            idx_in        = idx_ff + IDX_W'(1);
            if (list_last) begin
               state_in = S_IDLE;
            end
         end
         S_AGE: begin
            if (any_kill) begin
               cmd.op     = hbr_pkg::CELL_PULL;
               occ_in     = occ_ff - CNT_W'(1);
               removed_in = removed_ff + CNT_W'(1);
            end else begin
               out_valid_in  = 1'b1;
               out_status_in = hbr_pkg::ST_TICK_DONE;
               out_ip_in     = '0;
               out_port_in   = '0;
               out_count_in  = COUNT_W'(removed_ff);
               out_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         occ_ff       <= '0;
         out_valid_ff <= 1'b0;
         timeout_ff   <= hbr_pkg::TIMEOUT_RESET;
         local_ip_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               hbr_pkg::REG_TIMEOUT:  timeout_ff  <= csr_wdata[15:0];
               hbr_pkg::REG_LOCAL_IP: local_ip_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      class_ff      <= class_in;
      removed_ff    <= removed_in;
      idx_ff        <= idx_in;
      key_ip_ff     <= key_ip_in;
      port_ff       <= port_in;
      now_ff        <= now_in;
      out_status_ff <= out_status_in;
      out_ip_ff     <= out_ip_in;
      out_port_ff   <= out_port_in;
      out_count_ff  <= out_count_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_entry_ip    = out_ip_ff;
   assign rsp_entry_port  = out_port_ff;
   assign rsp_entry_count = out_count_ff;
   assign rsp_last        = out_last_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CNT_W'(DEPTH))
      else $error("occupancy above table depth");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("request accepted without going busy");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !busy)
      else $error("final result while still busy");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !busy && !start |=> !rsp_valid)
      else $error("result without a request");

endmodule

@@ test/registry_checker.sv @@
// Checker for the heartbeat registry: watches the request, result and register
// ports, predicts the replies of each accepted request and compares them in order.
// Depends on hbr_pkg.
module registry_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic        req_mode,
   input  logic [7:0]  req_first_byte,
   input  logic [7:0]  req_second_byte,
   input  logic [31:0] req_src_ip,
   input  logic [15:0] req_src_port,
   input  logic [31:0] req_now_seconds,
   input  logic        rsp_valid,
   input  logic [3:0]  rsp_status,
   input  logic [31:0] rsp_entry_ip,
   input  logic [15:0] rsp_entry_port,
   input  logic [4:0]  rsp_entry_count,
   input  logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata,
   output int          errors,
   output int          replies_due
);

   typedef struct {
      logic [3:0]  status;
      logic [31:0] ip;
      logic [15:0] port;
      logic [4:0]  count;
      logic        last;
   } reply_type;

   reply_type          pending_replies[$];
   hbr_pkg::entry_type peers[hbr_pkg::TABLE_DEPTH];
   int                 occupancy = 0;
   logic [15:0]        timeout_secs = hbr_pkg::TIMEOUT_RESET;
   logic [31:0]        local_addr = '0;
   int                 mismatch_count = 0;

   task automatic push_reply(input hbr_pkg::status_type st, input logic [31:0] ip,
                             input logic [15:0] port, input logic [4:0] cnt,
                             input logic last);
      reply_type r;
      r.status = st;
      r.ip     = ip;
      r.port   = port;
      r.count  = cnt;
      r.last   = last;
      pending_replies.push_back(r);
   endtask

   task automatic remove_peer(input int pos);
      for (int j = pos; j + 1 < occupancy; j++) peers[j] = peers[j + 1];
      occupancy--;
   endtask

   function automatic int find_peer(input logic [31:0] ip, input logic [15:0] port);
      for (int j = 0; j < occupancy; j++)
         if (peers[j].ip == ip && peers[j].port == port) return j;
      return -1;
   endfunction

   task automatic compute_replies();
      logic [31:0] key_ip;
      logic [32:0] expiry;
      logic [4:0]  removed;
      int          pos;
      int          i;
      key_ip  = req_src_ip;
      removed = '0;
      if (req_mode) begin
         i = 0;
         while (i < occupancy) begin
            expiry = {1'b0, peers[i].seen} + {17'b0, timeout_secs};
            if (expiry < {1'b0, req_now_seconds}) begin
               remove_peer(i);
               removed++;
            end else begin
               i++;
            end
         end
         push_reply(hbr_pkg::ST_TICK_DONE, '0, '0, removed, 1'b1);
      end else if (req_second_byte == hbr_pkg::MSG_KEEPALIVE ||
                   req_second_byte == hbr_pkg::MSG_ADD ||
                   req_second_byte == hbr_pkg::MSG_CLOSE) begin
         if (key_ip == hbr_pkg::LOOPBACK_IP && local_addr != '0) key_ip = local_addr;
         pos = find_peer(key_ip, req_src_port);
         if (req_second_byte == hbr_pkg::MSG_CLOSE) begin
            if (pos >= 0) begin
               remove_peer(pos);
               push_reply(hbr_pkg::ST_REMOVED, key_ip, req_src_port, '0, 1'b1);
            end else begin
               push_reply(hbr_pkg::ST_NOT_FOUND, key_ip, req_src_port, '0, 1'b1);
            end
         end else if (pos >= 0) begin
            peers[pos].seen = req_now_seconds;
            push_reply(hbr_pkg::ST_REFRESHED, key_ip, req_src_port, '0, 1'b1);
         end else if (occupancy < hbr_pkg::TABLE_DEPTH) begin
            for (i = occupancy; i > 0; i--) peers[i] = peers[i - 1];
            peers[0].ip   = key_ip;
            peers[0].port = req_src_port;
            peers[0].seen = req_now_seconds;
            occupancy++;
            push_reply(hbr_pkg::ST_ADDED, key_ip, req_src_port, '0, 1'b1);
         end else begin
            push_reply(hbr_pkg::ST_FULL, key_ip, req_src_port, '0, 1'b1);
         end
      end else if (req_second_byte == hbr_pkg::MSG_LIST ||
                   (req_first_byte == 8'h00 && req_second_byte == hbr_pkg::MSG_QUERY)) begin
         push_reply(hbr_pkg::ST_HEADER, '0, '0, 5'(occupancy), occupancy == 0);
         for (i = 0; i < occupancy; i++)
            push_reply(hbr_pkg::ST_ENTRY, peers[i].ip, peers[i].port, '0,
                       i + 1 == occupancy);
      end else begin
         push_reply(hbr_pkg::ST_UNKNOWN, req_src_ip, req_src_port, '0, 1'b1);
      end
   endtask

   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         timeout_secs = hbr_pkg::TIMEOUT_RESET;
         local_addr   = '0;
         occupancy    = 0;
         pending_replies.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               hbr_pkg::REG_TIMEOUT:  timeout_secs = csr_wdata[15:0];
               hbr_pkg::REG_LOCAL_IP: local_addr   = csr_wdata;
            endcase
         end
         if (start && !busy) compute_replies();
         if (rsp_valid) begin
            if (pending_replies.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected reply: status %0d ip %h port %h count %0d last %b",
                           rsp_status, rsp_entry_ip, rsp_entry_port, rsp_entry_count,
                           rsp_last);
            end else begin
               want = pending_replies.pop_front();
               if (rsp_status !== want.status || rsp_entry_ip !== want.ip ||
                   rsp_entry_port !== want.port || rsp_entry_count !== want.count ||
                   rsp_last !== want.last) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"reply mismatch: expected status %0d ip %h port %h ",
                               "count %0d last %b, got status %0d ip %h port %h ",
                               "count %0d last %b"},
                              want.status, want.ip, want.port, want.count, want.last,
                              rsp_status, rsp_entry_ip, rsp_entry_port, rsp_entry_count,
                              rsp_last);
               end
            end
         end
      end
      errors      <= mismatch_count;
      replies_due <= pending_replies.size();
   end

endmodule

@@ test/testbench.sv @@
// Top of the heartbeat registry test: clock, reset, directed and random requests,
// register writes between phases, watchdog and verdict.
// Depends on hbr_pkg, heartbeat_registry_with_aging and registry_checker.
module testbench;

   localparam int STALL_LIMIT = 2000;
   localparam int POOL        = 24;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_mode;
   logic [7:0]  req_first_byte;
   logic [7:0]  req_second_byte;
   logic [31:0] req_src_ip;
   logic [15:0] req_src_port;
   logic [31:0] req_now_seconds;
   logic        rsp_valid;
   logic [3:0]  rsp_status;
   logic [31:0] rsp_entry_ip;
   logic [15:0] rsp_entry_port;
   logic [4:0]  rsp_entry_count;
   logic        rsp_last;
   logic        csr_wr_en;
   logic        csr_index;
   logic [31:0] csr_wdata;
   int          errors;
   int          replies_due;

   int          stall_cycles = 0;
   int          idle_max = 7;
   logic [31:0] now_s;
   logic [15:0] cur_timeout;
   logic [31:0] cur_local;
   logic [31:0] pool_ip[POOL];
   logic [15:0] pool_port[POOL];

   heartbeat_registry_with_aging dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_first_byte(req_first_byte),
      .req_second_byte(req_second_byte), .req_src_ip(req_src_ip),
      .req_src_port(req_src_port), .req_now_seconds(req_now_seconds),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_entry_ip(rsp_entry_ip),
      .rsp_entry_port(rsp_entry_port), .rsp_entry_count(rsp_entry_count),
      .rsp_last(rsp_last), .csr_wr_en(csr_wr_en), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   registry_checker u_registry_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_first_byte(req_first_byte),
      .req_second_byte(req_second_byte), .req_src_ip(req_src_ip),
      .req_src_port(req_src_port), .req_now_seconds(req_now_seconds),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_entry_ip(rsp_entry_ip),
      .rsp_entry_port(rsp_entry_port), .rsp_entry_count(rsp_entry_count),
      .rsp_last(rsp_last), .csr_wr_en(csr_wr_en), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .errors(errors), .replies_due(replies_due)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic send_request(input logic mode, input logic [7:0] b0,
                               input logic [7:0] b1, input logic [31:0] ip,
                               input logic [15:0] port);
      int gap;
      gap = $urandom_range(0, idle_max);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_mode        = mode;
      req_first_byte  = b0;
      req_second_byte = b1;
      req_src_ip      = ip;
      req_src_port    = port;
      req_now_seconds = now_s;
      start           = 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic drain();
      start = 1'b0;
      while (replies_due != 0 || busy) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [31:0] data);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic advance_time();
      logic [32:0] next;
      if ($urandom_range(0, 19) == 0)
         next = {1'b0, now_s} + cur_timeout + $urandom_range(1, 100);
      else
         next = {1'b0, now_s} + $urandom_range(0, (cur_timeout >> 5) + 1);
      now_s = next[32] ? 32'hFFFF_FFFF : next[31:0];
   endtask

   initial begin
      logic [7:0]  rb;
      logic [31:0] rip;
      logic [15:0] rport;
      logic [32:0] jump;
      int          r;
      int          k;
      start           = 1'b0;
      req_mode        = 1'b0;
      req_first_byte  = '0;
      req_second_byte = '0;
      req_src_ip      = '0;
      req_src_port    = '0;
      req_now_seconds = '0;
      csr_wr_en       = 1'b0;
      csr_index       = hbr_pkg::REG_TIMEOUT;
      csr_wdata       = '0;
      now_s           = 32'd100;
      cur_timeout     = hbr_pkg::TIMEOUT_RESET;
      cur_local       = '0;
      reset           = 1'b1;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      send_request(1'b0, 8'h00, hbr_pkg::MSG_LIST, 32'h0, 16'h0);
      send_request(1'b0, 8'h00, hbr_pkg::MSG_QUERY, 32'h1234_5678, 16'h9ABC);
      send_request(1'b0, 8'h01, hbr_pkg::MSG_QUERY, 32'h1234_5678, 16'h9ABC);
      send_request(1'b0, 8'hFF, hbr_pkg::MSG_ADD, 32'h0, 16'h0);
      send_request(1'b0, 8'h00, hbr_pkg::MSG_KEEPALIVE, 32'hFFFF_FFFF, 16'hFFFF);
      now_s = 32'd110;
      send_request(1'b0, 8'h5A, hbr_pkg::MSG_KEEPALIVE, 32'hFFFF_FFFF, 16'hFFFF);
      send_request(1'b0, 8'hA5, hbr_pkg::MSG_ADD, hbr_pkg::LOOPBACK_IP, 16'd26950);
      send_request(1'b0, 8'hFF, hbr_pkg::MSG_LIST, 32'hFFFF_FFFF, 16'hFFFF);
      send_request(1'b0, 8'h00, hbr_pkg::MSG_CLOSE, 32'h0, 16'h0);
      send_request(1'b0, 8'h00, hbr_pkg::MSG_CLOSE, 32'h0, 16'h0);
      send_request(1'b0, 8'hFF, 8'h00, 32'hDEAD_BEEF, 16'h1234);
      send_request(1'b0, 8'h00, 8'hFF, 32'h8000_0001, 16'h8001);
      send_request(1'b1, 8'h00, 8'h00, 32'h0, 16'h0);
      now_s = 32'd562;
      send_request(1'b1, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF);

      drain();
      cur_timeout = 16'd1;
      cur_local   = 32'h0A00_0001;
      write_reg(hbr_pkg::REG_TIMEOUT, {16'h0, cur_timeout});
      write_reg(hbr_pkg::REG_LOCAL_IP, cur_local);
      send_request(1'b0, 8'h00, hbr_pkg::MSG_KEEPALIVE, hbr_pkg::LOOPBACK_IP, 16'd26950);
      send_request(1'b0, 8'h00, hbr_pkg::MSG_ADD, 32'h0A00_0001, 16'd26950);
      send_request(1'b0, 8'h00, hbr_pkg::MSG_CLOSE, hbr_pkg::LOOPBACK_IP, 16'd26950);
      send_request(1'b0, 8'h00, hbr_pkg::MSG_ADD, hbr_pkg::LOOPBACK_IP, 16'd7);
      now_s = 32'd563;
      send_request(1'b1, 8'h00, 8'h00, 32'h0, 16'h0);
      now_s = 32'd564;
      send_request(1'b1, 8'h00, 8'h00, 32'h0, 16'h0);

      drain();
      cur_timeout = 16'd0;
      cur_local   = 32'hFFFF_FFFF;
      write_reg(hbr_pkg::REG_TIMEOUT, {16'h0, cur_timeout});
      write_reg(hbr_pkg::REG_LOCAL_IP, cur_local);
      send_request(1'b0, 8'h00, hbr_pkg::MSG_ADD, hbr_pkg::LOOPBACK_IP, 16'd1);
      send_request(1'b1, 8'h00, 8'h00, 32'h0, 16'h0);
      now_s = 32'd565;
      send_request(1'b1, 8'h00, 8'h00, 32'h0, 16'h0);

      for (int phase = 0; phase < 6; phase++) begin
         drain();
         case (phase)
            0: begin
               cur_timeout = hbr_pkg::TIMEOUT_RESET;
               cur_local   = '0;
               idle_max    = 7;
            end
            1: begin cur_timeout = 16'hFFFF; cur_local = $urandom; idle_max = 0; end
            2: begin cur_timeout = 16'd1; cur_local = 32'hFFFF_FFFF; idle_max = 7; end
            3: begin cur_timeout = 16'd0; cur_local = hbr_pkg::LOOPBACK_IP; idle_max = 3; end
            4: begin
               cur_timeout = 16'($urandom_range(2, 2000));
               cur_local   = $urandom;
               idle_max    = 7;
            end
            default: begin cur_timeout = 16'hFFFF; cur_local = '0; idle_max = 7; end
         endcase
         write_reg(hbr_pkg::REG_TIMEOUT, {16'h0, cur_timeout});
         write_reg(hbr_pkg::REG_LOCAL_IP, cur_local);
         if (phase == 5) begin
            now_s = 32'hFFFF_0000 | ($urandom & 32'h0000_7FFF);
         end else if (phase > 0) begin
            jump  = {1'b0, now_s} + $urandom_range(0, 32'h1FFF_FFFF);
            now_s = jump[31:0];
         end
         for (k = 0; k < POOL; k++) begin
            pool_ip[k]   = $urandom;
            pool_port[k] = 16'($urandom);
            if (k % 6 == 0) pool_ip[k] = hbr_pkg::LOOPBACK_IP;
            else if (k % 6 == 1) pool_ip[k] = cur_local;
            else if (k % 6 == 2) pool_ip[k] = pool_ip[k - 2];
            if (k % 8 == 3) pool_port[k] = 16'd26950;
         end
         repeat (75) begin
            advance_time();
            r     = $urandom_range(0, 99);
            k     = $urandom_range(0, POOL - 1);
            rb    = 8'($urandom);
            rip   = $urandom;
            rport = 16'($urandom);
            if (r < 40)
               send_request(1'b0, rb,
                            $urandom_range(0, 1) ? hbr_pkg::MSG_ADD
                                                 : hbr_pkg::MSG_KEEPALIVE,
                            pool_ip[k], pool_port[k]);
            else if (r < 52)
               send_request(1'b0, rb, hbr_pkg::MSG_CLOSE, pool_ip[k], pool_port[k]);
            else if (r < 56)
               send_request(1'b0, rb, hbr_pkg::MSG_LIST, rip, rport);
            else if (r < 60)
               send_request(1'b0, 8'h00, hbr_pkg::MSG_QUERY, rip, rport);
            else if (r < 72)
               send_request(1'b1, rb, rip[31:24], rip, rport);
            else if (r < 80)
               send_request(1'b0, 8'($urandom_range(1, 255)), hbr_pkg::MSG_QUERY,
                            rip, rport);
            else
               send_request(1'b0, rb, rip[7:0], rip, rport);
         end
      end

      drain();
      repeat (20) @(negedge clock);
      if (errors == 0 && replies_due == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule
